### rtl/aosq_pkg.sv
// Package for the ADC oversampling scan sequencer.
// Holds widths, register index codes and the derived-configuration struct.
// No dependencies.
package aosq_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MAX_SLOTS_DEF   = 16;

    localparam int ACC_W       = 28;
    localparam int COUNT_W     = 17;
    localparam int SLOT_W      = 4;
    localparam int CHAN_W      = 5;
    localparam int VALUE_W     = 16;
    localparam int CFG_FIELD_W = 5;
    localparam int CFG_DATA_W  = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int DEPTH_LIMIT = 16;
    localparam int LIST_SLOTS  = 16;
    localparam int CHAN_LIST_W = LIST_SLOTS * CHAN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT   = 3'd0,
        CFG_OVERSAMPLE_LOG2 = 3'd1,
        CFG_EXTRA_BITS      = 3'd2,
        CFG_LIST_LOW        = 3'd3,
        CFG_LIST_HIGH       = 3'd4
    } cfg_index_t;

    // Configuration after clamping, as the datapath uses it
    typedef struct packed {
        logic [CFG_FIELD_W-1:0] depth;
        logic [CFG_FIELD_W-1:0] shift;
        logic [CFG_FIELD_W-1:0] count_lim;
        logic [CHAN_LIST_W-1:0] chan_list;
    } cfg_t;

endpackage

### rtl/aosq_if.sv
// Handshake channel interfaces of the oversampling scan sequencer.
// Depends on aosq_pkg for field widths.
interface aosq_sample_if
    import aosq_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface aosq_result_if
    import aosq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               frame_done;
    logic [CHAN_W-1:0]  next_channel;

    modport source (output valid, output slot, output value, output frame_done,
                    output next_channel, input ready);
    modport sink   (input valid, input slot, input value, input frame_done,
                    input next_channel, output ready);
endinterface

interface aosq_cfg_if
    import aosq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/aosq_cfg_regs.sv
// Configuration registers and their clamping into cfg_t.
// Depends on aosq_pkg.
module aosq_cfg_regs
    import aosq_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_IDX_W-1:0]   wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    logic [CFG_FIELD_W-1:0] ch_count_reg, ch_count_next;
    logic [CFG_FIELD_W-1:0] ol2_reg,      ol2_next;
    logic [CFG_FIELD_W-1:0] extra_reg,    extra_next;
    logic [CFG_DATA_W-1:0]  list_lo_reg,  list_lo_next;
    logic [CFG_DATA_W-1:0]  list_hi_reg,  list_hi_next;

    always_comb
    begin
        ch_count_next = ch_count_reg;
        ol2_next      = ol2_reg;
        extra_next    = extra_reg;
        list_lo_next  = list_lo_reg;
        list_hi_next  = list_hi_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_CHANNEL_COUNT:   ch_count_next = wr_data[CFG_FIELD_W-1:0];
                CFG_OVERSAMPLE_LOG2: ol2_next      = wr_data[CFG_FIELD_W-1:0];
                CFG_EXTRA_BITS:      extra_next    = wr_data[CFG_FIELD_W-1:0];
                CFG_LIST_LOW:        list_lo_next  = wr_data;
                CFG_LIST_HIGH:       list_hi_next  = wr_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_count_reg <= CFG_FIELD_W'(1);
            ol2_reg      <= CFG_FIELD_W'(1);
            extra_reg    <= '0;
            list_lo_reg  <= '0;
            list_hi_reg  <= '0;
        end
        else
        begin
            ch_count_reg <= ch_count_next;
            ol2_reg      <= ol2_next;
            extra_reg    <= extra_next;
            list_lo_reg  <= list_lo_next;
            list_hi_reg  <= list_hi_next;
        end
    end

    logic [CFG_FIELD_W-1:0] depth;
    logic [CFG_FIELD_W-1:0] extra;

    // Clamp depth to the limit, extra bits to depth, count to 1..MAX_SLOTS
    always_comb
    begin
        depth = (ol2_reg > CFG_FIELD_W'(DEPTH_LIMIT)) ? CFG_FIELD_W'(DEPTH_LIMIT) : ol2_reg;
        extra = (extra_reg > depth) ? depth : extra_reg;
        cfg.depth = depth;
        cfg.shift = depth - extra;
        if (ch_count_reg == '0)
            cfg.count_lim = CFG_FIELD_W'(1);
        else if (ch_count_reg > CFG_FIELD_W'(MAX_SLOTS))
            cfg.count_lim = CFG_FIELD_W'(MAX_SLOTS);
        else
            cfg.count_lim = ch_count_reg;
        cfg.chan_list = {list_hi_reg, list_lo_reg};
    end

endmodule

### rtl/aosq_accum.sv
// Accumulate, slot sequencing and result register.
// Depends on aosq_pkg.
module aosq_accum
    import aosq_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    output logic                   take,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SLOT_W-1:0]      out_slot,
    output logic [VALUE_W-1:0]     out_value,
    output logic                   out_frame_done,
    output logic [CHAN_W-1:0]      out_next_channel
);

    logic [ACC_W-1:0]   acc_reg,   acc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]  slot_reg,  slot_next;
    logic               valid_reg, valid_next;

    logic [SLOT_W-1:0]  res_slot_reg,  res_slot_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_done_reg,  res_done_next;
    logic [CHAN_W-1:0]  res_chan_reg,  res_chan_next;

    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] target;
    logic               emit;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_sat;
    logic [ACC_W-1:0]   shifted;
    logic [SLOT_W-1:0]  slot_inc;
    logic               wrap;
    logic [SLOT_W-1:0]  new_slot;
    logic [6:0]         chan_base;
    logic [CHAN_W-1:0]  listed;

    always_comb
    begin
        count_inc = count_reg + COUNT_W'(1);
        target    = COUNT_W'(1) << cfg.depth;
        emit      = (count_inc >= target);
        take      = in_valid && (!emit || !valid_reg || out_ready);

        acc_sum = {1'b0, acc_reg} + (ACC_W+1)'(in_sample);
        acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        shifted = acc_sat >> cfg.shift;

        slot_inc  = slot_reg + SLOT_W'(1);
        wrap      = (slot_inc == '0) || ({1'b0, slot_inc} >= cfg.count_lim);
        new_slot  = wrap ? '0 : slot_inc;
        chan_base = {3'b000, new_slot} * 7'(CHAN_W);
        listed    = cfg.chan_list[chan_base +: CHAN_W];

        acc_next       = acc_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        res_slot_next  = res_slot_reg;
        res_value_next = res_value_reg;
        res_done_next  = res_done_reg;
        res_chan_next  = res_chan_reg;
        valid_next     = out_ready ? 1'b0 : valid_reg;

        if (take)
        begin
            if (emit)
            begin
                acc_next       = '0;
                count_next     = '0;
                slot_next      = new_slot;
                valid_next     = 1'b1;
                res_slot_next  = slot_reg;
                res_value_next = (|shifted[ACC_W-1:VALUE_W]) ? {VALUE_W{1'b1}}
                                                           : shifted[VALUE_W-1:0];
                res_done_next  = wrap;
                res_chan_next  = listed + CHAN_W'(1);
            end
            else
            begin
                acc_next   = acc_sat;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_slot_reg  <= res_slot_next;
        res_value_reg <= res_value_next;
        res_done_reg  <= res_done_next;
        res_chan_reg  <= res_chan_next;
    end

    assign out_valid        = valid_reg;
    assign out_slot         = res_slot_reg;
    assign out_value        = res_value_reg;
    assign out_frame_done   = res_done_reg;
    assign out_next_channel = res_chan_reg;

`ifndef NO_ASSERTIONS
    // Count never runs beyond the largest target
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(1 << DEPTH_LIMIT))
        else $error("sample count beyond largest target");

    // A completed slot clears the running sum and count
    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |=> (count_reg == '0) && (acc_reg == '0))
        else $error("accumulator not cleared after result");

    // A new result appears only from an item that completed a slot
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !$past(valid_reg && !out_ready)) |-> $past(take && emit))
        else $error("result register loaded without completed slot");

    // A stalled result must not be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |-> !(take && emit))
        else $error("pending result overwritten");
`endif

endmodule

### rtl/adc_oversample_scan_sequencer_unit.sv
// Top level of the ADC oversampling scan sequencer.
// Depends on aosq_pkg, aosq_if, aosq_cfg_regs and aosq_accum.
//
//  channel   role    payload                                  handshake
//  -------   -----   --------------------------------------   -----------
//  cfg       sink    index, data (register write)             valid/ready
//  samples   sink    sample (one conversion)                  valid/ready
//  results   source  slot, value, frame_done, next_channel    valid/ready
//
// Flow: one item per cycle unless a result stalls; an accepted item passes through
//   the input register, then the result register, before its result leaves.
// Reset: rst_n clears accumulator, count, slot and valid flags at once;
//   configuration returns to one slot, depth one, no extra bits.
// Stalls: the input stalls only when a result waits in the result register
//   and the item in the input register would complete the next slot.
// Config writes are always ready and take effect on the next cycle.
module adc_oversample_scan_sequencer_unit
    import aosq_pkg::*;
#(
    parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    aosq_cfg_if.sink      cfg,
    aosq_sample_if.sink   samples,
    aosq_result_if.source results
);

    cfg_t cfg_cur;

    // Configuration is never back-pressured
    assign cfg.ready = 1'b1;

    aosq_cfg_regs #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_cur)
    );

    // Input register: holds one accepted item until the accumulator takes it
    logic                   in_valid_reg, in_valid_next;
    logic [SAMPLE_BITS-1:0] in_sample_reg, in_sample_next;
    logic                   take;
    logic                   in_ready;

    assign in_ready      = !in_valid_reg || take;
    assign samples.ready = in_ready;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_sample_next = in_sample_reg;
        if (samples.valid && in_ready)
        begin
            // load a fresh item, keeping the pipe full
            in_valid_next  = 1'b1;
            in_sample_next = samples.sample;
        end
        else if (take)
        begin
            // drop the slot once the accumulator has consumed it
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        in_sample_reg <= in_sample_next;
    end

    aosq_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_cur),
        .in_valid         (in_valid_reg),
        .in_sample        (in_sample_reg),
        .take             (take),
        .out_valid        (results.valid),
        .out_ready        (results.ready),
        .out_slot         (results.slot),
        .out_value        (results.value),
        .out_frame_done   (results.frame_done),
        .out_next_channel (results.next_channel)
    );

endmodule

### dv/aosq_scan_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the ADC oversampling scan sequencer: mirrors register writes,
// predicts slot results from accepted samples and compares them in order.
// Depends on aosq_pkg and the channel interfaces of aosq_if.
module aosq_scan_scoreboard
    import aosq_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)(
    input  logic   clk,
    input  logic   rst_n,
    aosq_cfg_if    cfg,
    aosq_sample_if samples,
    aosq_result_if results,
    output int     fail_count,
    output int     pending,
    output int     checked
);

    localparam logic [ACC_W-1:0] ACC_FULL   = '1;
    localparam int               VALUE_FULL = (1 << VALUE_W) - 1;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               frame_done;
        logic [CHAN_W-1:0]  next_channel;
    } slot_result_t;

    logic [CFG_FIELD_W-1:0] slot_count_reg;
    logic [CFG_FIELD_W-1:0] depth_reg;
    logic [CFG_FIELD_W-1:0] extra_reg;
    logic [CFG_DATA_W-1:0]  list_low_reg;
    logic [CFG_DATA_W-1:0]  list_high_reg;

    logic [ACC_W-1:0]       sum_acc;
    logic [COUNT_W-1:0]     samples_in_slot;
    logic [SLOT_W-1:0]      scan_slot;

    slot_result_t           awaited_results[$];

    function automatic logic [CHAN_W-1:0] listed_channel(input logic [SLOT_W-1:0] s);
        logic [CFG_DATA_W-1:0] lane;
        if (s < 8)
            lane = list_low_reg >> (CHAN_W * s);
        else
            lane = list_high_reg >> (CHAN_W * (s - 8));
        return lane[CHAN_W-1:0];
    endfunction

    function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] d);
        case (cfg_index_t'(idx))
            CFG_CHANNEL_COUNT:   slot_count_reg = d[CFG_FIELD_W-1:0];
            CFG_OVERSAMPLE_LOG2: depth_reg      = d[CFG_FIELD_W-1:0];
            CFG_EXTRA_BITS:      extra_reg      = d[CFG_FIELD_W-1:0];
            CFG_LIST_LOW:        list_low_reg   = d;
            CFG_LIST_HIGH:       list_high_reg  = d;
            default: ;
        endcase
    endfunction

    // Accumulate one sample; emit a slot result once the depth is reached or passed
    function automatic void fold_in_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
        int unsigned      depth;
        int unsigned      extra;
        int unsigned      lim;
        logic [ACC_W:0]   sum;
        logic [ACC_W-1:0] scaled;
        slot_result_t     r;
        depth = (depth_reg > DEPTH_LIMIT) ? DEPTH_LIMIT : depth_reg;
        extra = (extra_reg > depth) ? depth : extra_reg;
        lim   = (slot_count_reg == 0) ? 1 : slot_count_reg;
        if (lim > MAX_SLOTS)
            lim = MAX_SLOTS;
        sum = {1'b0, sum_acc} + (ACC_W+1)'(s);
        sum_acc = (sum > ACC_FULL) ? ACC_FULL : sum[ACC_W-1:0];
        samples_in_slot = samples_in_slot + 1'b1;
        if (int'(samples_in_slot) < (1 << depth))
            return;
        scaled  = sum_acc >> (depth - extra);
        r.slot  = scan_slot;
        r.value = (scaled > VALUE_FULL) ? '1 : scaled[VALUE_W-1:0];
        sum_acc = '0;
        samples_in_slot = '0;
        scan_slot = scan_slot + 1'b1;
        r.frame_done = 1'b0;
        if (scan_slot >= lim || scan_slot == 0)
        begin
            scan_slot    = '0;
            r.frame_done = 1'b1;
        end
        r.next_channel = listed_channel(scan_slot) + 1'b1;
        awaited_results.push_back(r);
    endfunction

    function automatic void check_result();
        slot_result_t want;
        if (awaited_results.size() == 0)
        begin
            $error("slot result with none awaited: slot %0d value %0d",
                   results.slot, results.value);
            fail_count++;
            return;
        end
        want = awaited_results.pop_front();
        checked++;
        if (results.slot !== want.slot)
        begin
            $error("field slot: expected %0d, actual %0d", want.slot, results.slot);
            fail_count++;
        end
        if (results.value !== want.value)
        begin
            $error("field value: expected %0d, actual %0d", want.value, results.value);
            fail_count++;
        end
        if (results.frame_done !== want.frame_done)
        begin
            $error("field frame_done: expected %0d, actual %0d",
                   want.frame_done, results.frame_done);
            fail_count++;
        end
        if (results.next_channel !== want.next_channel)
        begin
            $error("field next_channel: expected %0d, actual %0d",
                   want.next_channel, results.next_channel);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  = CFG_FIELD_W'(1);
            depth_reg       = CFG_FIELD_W'(1);
            extra_reg       = '0;
            list_low_reg    = '0;
            list_high_reg   = '0;
            sum_acc         = '0;
            samples_in_slot = '0;
            scan_slot       = '0;
            fail_count      = 0;
            checked         = 0;
            awaited_results.delete();
        end
        else
        begin
            if (results.valid && results.ready)
                check_result();
            if (cfg.valid && cfg.ready)
                mirror_write(cfg.index, cfg.data);
            if (samples.valid && samples.ready)
                fold_in_sample(samples.sample);
        end
        pending = awaited_results.size();
    end

endmodule

### dv/tb_adc_oversample_scan_sequencer_unit.sv
`timescale 1ns / 1ps
// Testbench top for the ADC oversampling scan sequencer: drives samples and
// register writes, stalls the result side and gives the verdict.
// Depends on aosq_pkg, aosq_if, the sequencer RTL and aosq_scan_scoreboard.
module tb_adc_oversample_scan_sequencer_unit;
    import aosq_pkg::*;

    // Results leave through the input register, then the result register; hold a little longer than that
    localparam int DRAIN_HOLD   = 4;
    localparam int RANDOM_ITEMS = 640;

    logic        clk;
    logic        rst_n;

    int          fail_count;
    int          pending;
    int          checked;
    int          items_sent;
    int          phases_run;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;

    aosq_cfg_if    cfg_ch ();
    aosq_sample_if samples_ch ();
    aosq_result_if results_ch ();

    adc_oversample_scan_sequencer_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (samples_ch),
        .results (results_ch)
    );

    aosq_scan_scoreboard i_scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .samples    (samples_ch),
        .results    (results_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: drop ready at random, at the rate the current mode asks
    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            results_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Hold valid high until the write is taken; the caller drops it after its last write,
    // so back-to-back writes never lower and raise valid in the same step
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Offer one sample after a random gap; valid stays high if no gap follows
    task automatic push_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid, let in-flight items land, then wait until every awaited result is in.
    // The second hold covers an item still inside the block that produces no result.
    task automatic settle();
        samples_ch.valid <= 1'b0;
        repeat (DRAIN_HOLD) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_HOLD) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample(input bit near_full);
        int unsigned roll;
        roll = $urandom_range(99);
        if (near_full)
            return (roll < 50) ? '1 : SAMPLE_BITS_DEF'($urandom_range(3800, 4095));
        if (roll < 12)
            return '0;
        if (roll < 24)
            return '1;
        return SAMPLE_BITS_DEF'($urandom);
    endfunction

    // Pick new settings for one phase. Depth stays small so results come often;
    // some phases keep every extra bit at depth 5 or 6 and feed near-full samples
    // so the 16-bit value saturates.
    task automatic retune(output bit near_full);
        int unsigned depth_v;
        int unsigned extra_v;
        near_full = ($urandom_range(99) < 12);
        if ($urandom_range(1) == 1)
            write_reg(CFG_CHANNEL_COUNT,
                      CFG_DATA_W'(($urandom_range(99) < 80) ? $urandom_range(1, 16)
                                                            : $urandom_range(0, 31)));
        if (near_full)
            depth_v = $urandom_range(5, 6);
        else
            depth_v = ($urandom_range(99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 6);
        if (near_full)
            extra_v = depth_v;
        else
            extra_v = ($urandom_range(99) < 85) ? $urandom_range(0, depth_v)
                                                : $urandom_range(0, 31);
        write_reg(CFG_OVERSAMPLE_LOG2, CFG_DATA_W'(depth_v));
        write_reg(CFG_EXTRA_BITS, CFG_DATA_W'(extra_v));
        if ($urandom_range(2) == 0)
            write_reg(CFG_LIST_LOW, {8'($urandom_range(255)), 32'($urandom)});
        if ($urandom_range(2) == 0)
            write_reg(CFG_LIST_HIGH, {8'($urandom_range(255)), 32'($urandom)});
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        bit          near_full;
        int unsigned n_items;
        int          rand_sent;

        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_CHANNEL_COUNT;
        cfg_ch.data       = '0;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        items_sent        = 0;
        phases_run        = 0;
        rand_sent         = 0;
        src_idle_pct      = 16;
        sink_idle_pct     = 73;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one slot, pairs of samples, result halved
        push_sample('0);
        push_sample('1);
        settle();

        // Depth zero: every sample is a result, unshifted
        write_reg(CFG_OVERSAMPLE_LOG2, CFG_DATA_W'(0));
        cfg_ch.valid <= 1'b0;
        push_sample('1);
        push_sample('0);
        push_sample(12'hA5A);
        settle();

        // Slot count zero acts as a single slot
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(0));
        cfg_ch.valid <= 1'b0;
        push_sample(12'h5A5);
        settle();

        // Slot count above the table size clamps to 16; extra bits above depth give no shift;
        // channel 31 in the list wraps the next channel to 0
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(31));
        write_reg(CFG_LIST_LOW, '1);
        write_reg(CFG_LIST_HIGH, 40'h84_2108_4210);
        write_reg(CFG_EXTRA_BITS, CFG_DATA_W'(7));
        cfg_ch.valid <= 1'b0;
        repeat (3) push_sample(pick_sample(1'b0));
        settle();

        // Lower the slot count below the current slot: next result wraps and ends the frame
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(2));
        cfg_ch.valid <= 1'b0;
        push_sample(12'h001);
        settle();

        // Lower the depth below the samples already summed: next sample completes the slot
        write_reg(CFG_OVERSAMPLE_LOG2, CFG_DATA_W'(3));
        cfg_ch.valid <= 1'b0;
        repeat (5) push_sample(pick_sample(1'b0));
        settle();
        write_reg(CFG_OVERSAMPLE_LOG2, CFG_DATA_W'(1));
        write_reg(CFG_EXTRA_BITS, CFG_DATA_W'(0));
        cfg_ch.valid <= 1'b0;
        push_sample('1);
        settle();

        // Random phases: stall mostly the result side, then mostly the sample side,
        // then run with no stalls at all
        while (rand_sent < RANDOM_ITEMS)
        begin
            if (rand_sent < RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 16;
                sink_idle_pct = 73;
            end
            else if (rand_sent < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 73;
                sink_idle_pct = 16;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            retune(near_full);
            n_items = near_full ? $urandom_range(64, 140) : $urandom_range(6, 48);
            for (int k = 0; k < n_items; k++)
                push_sample(pick_sample(near_full));
            rand_sent += n_items;
            phases_run++;
            settle();
        end

        // Depth above the limit acts as 2^16 samples, so a short run gives no result;
        // dropping to depth one then completes the slot on the next sample
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(16));
        write_reg(CFG_OVERSAMPLE_LOG2, CFG_DATA_W'(31));
        write_reg(CFG_EXTRA_BITS, CFG_DATA_W'(0));
        cfg_ch.valid <= 1'b0;
        repeat (24) push_sample(pick_sample(1'b1));
        settle();
        write_reg(CFG_OVERSAMPLE_LOG2, CFG_DATA_W'(1));
        cfg_ch.valid <= 1'b0;
        push_sample(pick_sample(1'b1));
        settle();

        // Depth 16 with every bit kept: nothing yet, then depth one with no shift saturates
        write_reg(CFG_OVERSAMPLE_LOG2, CFG_DATA_W'(DEPTH_LIMIT));
        write_reg(CFG_EXTRA_BITS, CFG_DATA_W'(31));
        cfg_ch.valid <= 1'b0;
        repeat (24) push_sample(pick_sample(1'b1));
        settle();
        write_reg(CFG_OVERSAMPLE_LOG2, CFG_DATA_W'(1));
        cfg_ch.valid <= 1'b0;
        push_sample(pick_sample(1'b1));
        settle();

        $display("Run covered %0d samples and %0d checked slot results over %0d random phases",
                 items_sent, checked, phases_run);
        $display("Depths 0 to beyond 16, slot counts 0 to 31, stalls on each side and none");
        if (fail_count == 0)
            $display("adc_oversample_scan_sequencer_unit test passed");
        else
            $display("adc_oversample_scan_sequencer_unit test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every stall at its worst
    initial
    begin
        #20_000_000;
        $display("adc_oversample_scan_sequencer_unit test failed");
        $finish;
    end

endmodule

### files.f
rtl/aosq_pkg.sv
rtl/aosq_if.sv
rtl/aosq_cfg_regs.sv
rtl/aosq_accum.sv
rtl/adc_oversample_scan_sequencer_unit.sv
dv/aosq_scan_scoreboard.sv
dv/tb_adc_oversample_scan_sequencer_unit.sv
